### rtl/tcw_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console cell writer
// Payload structs, command and status groups between controller and
// datapath, register indexes, mode codes and the cell formatting function.
// ---------------------------------------------------------------------------
package tcw_pkg;

  localparam int unsigned DEFAULT_ROWS    = 25;
  localparam int unsigned DEFAULT_COLUMNS = 80;

  localparam int unsigned CELL_W       = 16;
  localparam int unsigned ROW_OUT_W    = 5;
  localparam int unsigned COL_OUT_W    = 7;
  localparam int unsigned OFS_OUT_W    = 11;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 4;

  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0a;

  localparam logic [3:0] RESET_BG        = 4'h0;
  localparam logic [3:0] RESET_FG        = 4'hf;
  localparam logic       RESET_CURSOR_EN = 1'b1;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_BG        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FG        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CURSOR_EN = 2'd2;

  // Operation codes of the mode field
  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] char_code;
    logic       last_char;
    logic [4:0] cell_row;
    logic [6:0] cell_col;
  } in_item_t;

  typedef struct packed {
    logic [ROW_OUT_W-1:0] cursor_row;
    logic [COL_OUT_W-1:0] cursor_col;
    logic [OFS_OUT_W-1:0] cursor_offset;
    logic                 cursor_update;
    logic [CELL_W-1:0]    read_cell;
    logic                 scrolled;
  } out_item_t;

  typedef enum logic [1:0] {
    CUR_HOLD = 2'd0,
    CUR_ADV  = 2'd1,
    CUR_NL   = 2'd2,
    CUR_HOME = 2'd3
  } cur_op_t;

  typedef enum logic [2:0] {
    WS_NONE     = 3'd0,
    WS_IN_CHAR  = 3'd1,
    WS_REQ_CHAR = 3'd2,
    WS_COPY     = 3'd3,
    WS_BLANK    = 3'd4
  } wr_src_t;

  typedef struct packed {
    logic    start;
    cur_op_t cur_op;
    wr_src_t wr_src;
    logic    rd_walk;
    logic    walk_inc;
    logic    walk_clr;
    logic    set_scrolled;
    logic    blank_load;
    logic    cell_load;
    logic    out_load;
  } tcw_cmd_t;

  typedef struct packed {
    logic in_put;
    logic in_nl;
    logic in_clear;
    logic in_read;
    logic in_read_ok;
    logic col_full;
    logic last_row;
    logic walk_last_copy;
    logic walk_last;
    logic out_free;
  } tcw_status_t;

  localparam logic [CELL_W-1:0] RESET_CELL = {RESET_BG, RESET_FG, CHAR_SPACE};

  function automatic logic [CELL_W-1:0] make_cell(input logic [3:0] bg,
                                                  input logic [3:0] fg,
                                                  input logic [7:0] ch);
    return {bg, fg, ch};
  endfunction

endpackage
`default_nettype wire

### rtl/tcw_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tcw_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module tcw_ram #(
  parameter int unsigned WIDTH = tcw_pkg::CELL_W,
  parameter int unsigned DEPTH = tcw_pkg::DEFAULT_ROWS * tcw_pkg::DEFAULT_COLUMNS,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/tcw_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tcw_ctrl: controller of the text console cell writer
// Sequences character writes, reads, scroll copies and blanking walks.
// ---------------------------------------------------------------------------
module tcw_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire tcw_pkg::tcw_status_t status,
  output tcw_pkg::tcw_cmd_t         cmd
);
  import tcw_pkg::*;

  typedef enum logic [7:0] {
    ST_INIT    = 8'b0000_0001,
    ST_IDLE    = 8'b0000_0010,
    ST_READ    = 8'b0000_0100,
    ST_SCRL_RD = 8'b0000_1000,
    ST_SCRL_WR = 8'b0001_0000,
    ST_FILL    = 8'b0010_0000,
    ST_PUT     = 8'b0100_0000,
    ST_DONE    = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   pend_put, pend_put_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_INIT;
      pend_put <= 1'b0;
    end else begin
      state    <= state_next;
      pend_put <= pend_put_next;
    end
  end

  always_comb begin
    cmd           = '0;
    in_ready      = 1'b0;
    state_next    = state;
    pend_put_next = pend_put;
    unique case (state)
      ST_INIT: begin
        cmd.wr_src = WS_BLANK;
        if (status.walk_last) begin
          cmd.walk_clr = 1'b1;
          state_next   = ST_IDLE;
        end else begin
          cmd.walk_inc = 1'b1;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start     = 1'b1;
          pend_put_next = 1'b0;
          if (status.in_put) begin
            if (status.in_nl || status.col_full) begin
              cmd.cur_op = CUR_NL;
              if (status.last_row) begin
                // Leaving the last row: scroll first, then finish the step.
                cmd.set_scrolled = 1'b1;
                cmd.blank_load   = 1'b1;
                pend_put_next    = !status.in_nl;
                state_next       = ST_SCRL_RD;
              end else begin
                state_next = status.in_nl ? ST_DONE : ST_PUT;
              end
            end else begin
              cmd.wr_src = WS_IN_CHAR;
              cmd.cur_op = CUR_ADV;
              state_next = ST_DONE;
            end
          end else if (status.in_clear) begin
            cmd.cur_op     = CUR_HOME;
            cmd.blank_load = 1'b1;
            state_next     = ST_FILL;
          end else if (status.in_read && status.in_read_ok) begin
            state_next = ST_READ;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_READ: begin
        cmd.cell_load = 1'b1;
        state_next    = ST_DONE;
      end
      ST_SCRL_RD: begin
        cmd.rd_walk = 1'b1;
        state_next  = ST_SCRL_WR;
      end
      ST_SCRL_WR: begin
        cmd.wr_src   = WS_COPY;
        cmd.walk_inc = 1'b1;
        state_next   = status.walk_last_copy ? ST_FILL : ST_SCRL_RD;
      end
      ST_FILL: begin
        cmd.wr_src = WS_BLANK;
        if (status.walk_last) begin
          cmd.walk_clr = 1'b1;
          state_next   = pend_put ? ST_PUT : ST_DONE;
        end else begin
          cmd.walk_inc = 1'b1;
        end
      end
      ST_PUT: begin
        cmd.wr_src    = WS_REQ_CHAR;
        cmd.cur_op    = CUR_ADV;
        pend_put_next = 1'b0;
        state_next    = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/tcw_datapath.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tcw_datapath: datapath of the text console cell writer
// Cursor, configuration, walk counter, store addressing and result register.
// ---------------------------------------------------------------------------
module tcw_datapath #(
  parameter int unsigned ROWS    = tcw_pkg::DEFAULT_ROWS,
  parameter int unsigned COLUMNS = tcw_pkg::DEFAULT_COLUMNS,
  localparam int unsigned CELLS  = ROWS * COLUMNS,
  localparam int unsigned AW     = $clog2(CELLS)
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire tcw_pkg::in_item_t                      in_data,
  input  wire tcw_pkg::tcw_cmd_t                      cmd,
  output tcw_pkg::tcw_status_t                        status,
  input  wire logic                                   cfg_valid,
  input  wire logic [tcw_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [tcw_pkg::CFG_DATA_W-1:0]         cfg_data,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output tcw_pkg::out_item_t                          out_data,
  output logic                                        ram_we,
  output logic [AW-1:0]                               ram_waddr,
  output logic [tcw_pkg::CELL_W-1:0]                  ram_wdata,
  output logic [AW-1:0]                               ram_raddr,
  input  wire logic [tcw_pkg::CELL_W-1:0]             ram_rdata
);
  import tcw_pkg::*;

  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned CW    = $clog2(COLUMNS + 1);
  localparam int unsigned OFS_W = $clog2(CELLS + 1);
  localparam int unsigned OW    = (OFS_W > OFS_OUT_W) ? OFS_W : OFS_OUT_W;
  localparam int unsigned RXW   = (RW > ROW_OUT_W) ? RW : ROW_OUT_W;
  localparam int unsigned CXW   = (CW > COL_OUT_W) ? CW : COL_OUT_W;

  logic [3:0]        bg;
  logic [3:0]        fg;
  logic              cursor_en;
  logic [RW-1:0]     row, row_next;
  logic [CW-1:0]     col, col_next;
  logic [AW-1:0]     walk;
  logic [CELL_W-1:0] blank_val;
  logic [CELL_W-1:0] rd_cell;
  logic              scrolled;
  in_item_t          req;
  logic [OW-1:0]     cur_lin;
  logic [AW-1:0]     in_addr;
  logic              update;
  logic [RXW-1:0]    row_x;
  logic [CXW-1:0]    col_x;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bg        <= RESET_BG;
      fg        <= RESET_FG;
      cursor_en <= RESET_CURSOR_EN;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BG:        bg        <= cfg_data;
        REG_FG:        fg        <= cfg_data;
        REG_CURSOR_EN: cursor_en <= cfg_data[0];
        default:       ;
      endcase
    end
  end

  // Cursor
  always_comb begin
    row_next = row;
    col_next = col;
    case (cmd.cur_op)
      CUR_ADV: col_next = col + CW'(1);
      CUR_NL: begin
        col_next = '0;
        if (!status.last_row) begin
          row_next = row + RW'(1);
        end
      end
      CUR_HOME: begin
        row_next = '0;
        col_next = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else begin
      row <= row_next;
      col <= col_next;
    end
  end

  // Walk counter over the store, back at zero whenever a walk ends
  always_ff @(posedge clk) begin
    if (rst) begin
      walk <= '0;
    end else if (cmd.walk_clr) begin
      walk <= '0;
    end else if (cmd.walk_inc) begin
      walk <= walk + AW'(1);
    end
  end

  // The blank cell is taken at the start of each blanking walk, so that the
  // pass after reset uses the reset colours whatever is written meanwhile.
  always_ff @(posedge clk) begin
    if (rst) begin
      blank_val <= RESET_CELL;
    end else if (cmd.blank_load) begin
      blank_val <= make_cell(bg, fg, CHAR_SPACE);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_cell  <= '0;
      scrolled <= 1'b0;
    end else begin
      if (cmd.start) begin
        rd_cell <= '0;
      end else if (cmd.cell_load) begin
        rd_cell <= ram_rdata;
      end
      if (cmd.set_scrolled) begin
        scrolled <= 1'b1;
      end else if (cmd.start) begin
        scrolled <= 1'b0;
      end
    end
  end

  assign cur_lin = OW'(row) * OW'(COLUMNS) + OW'(col);
  assign in_addr = AW'(int'(in_data.cell_row) * COLUMNS + int'(in_data.cell_col));

  // Store addressing
  always_comb begin
    ram_we    = 1'b1;
    ram_waddr = walk;
    ram_wdata = blank_val;
    case (cmd.wr_src)
      WS_IN_CHAR: begin
        ram_waddr = cur_lin[AW-1:0];
        ram_wdata = make_cell(bg, fg, in_data.char_code);
      end
      WS_REQ_CHAR: begin
        ram_waddr = cur_lin[AW-1:0];
        ram_wdata = make_cell(bg, fg, req.char_code);
      end
      WS_COPY:  ram_wdata = ram_rdata;
      WS_BLANK: ram_wdata = blank_val;
      default:  ram_we = 1'b0;
    endcase
  end

  assign ram_raddr = cmd.rd_walk ? walk + AW'(COLUMNS) : in_addr;

  // Status towards the controller
  always_comb begin
    status.in_put         = (in_data.mode == MODE_PUT);
    status.in_nl          = (in_data.char_code == CHAR_NEWLINE);
    status.in_clear       = (in_data.mode == MODE_CLEAR);
    status.in_read        = (in_data.mode == MODE_READ);
    status.in_read_ok     = (int'(in_data.cell_row) < ROWS) &&
                            (int'(in_data.cell_col) < COLUMNS);
    status.col_full       = (col == CW'(COLUMNS));
    status.last_row       = (row == RW'(ROWS - 1));
    status.walk_last_copy = (walk == AW'(CELLS - COLUMNS - 1));
    status.walk_last      = (walk == AW'(CELLS - 1));
    status.out_free       = !out_valid || out_ready;
  end

  // Result register
  assign update = (req.mode == MODE_PUT) && req.last_char && cursor_en &&
                  (col < CW'(COLUMNS));
  assign row_x  = RXW'(row);
  assign col_x  = CXW'(col);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.cursor_row    <= row_x[ROW_OUT_W-1:0];
      out_data.cursor_col    <= col_x[COL_OUT_W-1:0];
      out_data.cursor_offset <= cur_lin[OFS_OUT_W-1:0];
      out_data.cursor_update <= update;
      out_data.read_cell     <= rd_cell;
      out_data.scrolled      <= scrolled;
    end
  end

endmodule
`default_nettype wire

### rtl/text_console_cell_writer_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// text_console_cell_writer_top: text-mode console cell writer
// Owns a ROWS x COLUMNS grid of character cells with a cursor.
// ---------------------------------------------------------------------------
// Commands arrive on the in channel (put, clear, read), one result per
// command leaves on the out channel; colours and cursor enable are written on
// the cfg channel, which is always ready. All channels use valid/ready and a
// transfer happens when both are high.
// Work per command, set by the single write port of the cell store:
//   put of a printable character      one cell write
//   put of a character on a full line line step, then the write (when not on the last row)
//   read                              one cell read
//   newline off the last row scrolls:
//     one read and one write per copied cell, then one write per blanked
//     cell of the bottom row; a wrapping character there is written after
//     the scroll
//   clear                             one write per cell of the grid
// After reset a clearing pass blanks every cell of the store with
// the reset colours; in_ready stays low meanwhile. A result waits in the
// output register while the receiver stalls, and the next command is still
// taken; it completes once the register is free.
// ---------------------------------------------------------------------------
module text_console_cell_writer_top #(
  parameter int unsigned ROWS    = tcw_pkg::DEFAULT_ROWS,
  parameter int unsigned COLUMNS = tcw_pkg::DEFAULT_COLUMNS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire tcw_pkg::in_item_t              in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output tcw_pkg::out_item_t                  out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tcw_pkg::*;

  localparam int unsigned CELLS = ROWS * COLUMNS;
  localparam int unsigned AW    = $clog2(CELLS);

  tcw_cmd_t          cmd;
  tcw_status_t       status;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  assign cfg_ready = 1'b1;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tcw_datapath #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // A command is worked on alone: no second transfer straight after one.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a command is in progress");

  // The cursor is only shown when it sits inside the line.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.cursor_update) |-> (int'(out_data.cursor_col) < COLUMNS))
    else $error("cursor update reported on a full line");

  // A scroll leaves the cursor at the start of the bottom line, or just after a character that wrapped.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.scrolled) |->
      (out_data.cursor_col == '0 || out_data.cursor_col == COL_OUT_W'(1)))
    else $error("scroll left the cursor away from the line start");

  // The store is never written while waiting for a command.
  assert property (@(posedge clk) disable iff (rst)
    (in_ready && !in_valid) |-> !ram_we)
    else $error("cell store written while idle");

endmodule
`default_nettype wire

### verif/tb_text_console_cell_writer_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_text_console_cell_writer_top: self-checking bench for the console writer
// Drives put, clear, read and unused commands through the valid/ready input
// channel and compares every result against a behavioural copy of the cell
// grid and cursor. Covers line wrap, scrolling on the last row, reads out of
// range, colour and cursor-enable settings, and a long receiver hold-off.
// ---------------------------------------------------------------------------
module tb_text_console_cell_writer_top;
  import tcw_pkg::*;

  localparam int unsigned ROWS    = DEFAULT_ROWS;
  localparam int unsigned COLUMNS = DEFAULT_COLUMNS;
  localparam int unsigned CELLS   = ROWS * COLUMNS;

  localparam logic [1:0]           MODE_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONE    = 2'd3;

  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned MAX_REPORTS = 40;
  // The timeout is ample even if every command scrolled, the slowest kind.
  localparam longint unsigned TIMEOUT_NS = 64'd100_000_000;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Mirror of the console: cell grid, cursor and register settings.
  logic [CELL_W-1:0] screen [CELLS];
  int unsigned       cur_row;
  int unsigned       cur_col;
  logic [3:0]        bg_colour;
  logic [3:0]        fg_colour;
  logic              cursor_on;

  out_item_t expected_results [$];

  int unsigned in_idle_pct  = 19;
  int unsigned out_idle_pct = 55;
  int unsigned hold_request = 0;
  int unsigned hold_left    = 0;

  int unsigned err_count = 0;
  int unsigned n_sent    = 0;
  int unsigned n_checked = 0;
  int unsigned n_scrolls = 0;
  int unsigned n_clears  = 0;
  int unsigned n_reads   = 0;

  text_console_cell_writer_top #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // ------------------------------------------------------------------------
  // Console behaviour
  // ------------------------------------------------------------------------
  function automatic logic [CELL_W-1:0] coloured(input logic [7:0] ch);
    return {bg_colour, fg_colour, ch};
  endfunction

  function automatic void blank_from(input int unsigned first);
    for (int unsigned i = first; i < CELLS; i++) screen[i] = coloured(CHAR_SPACE);
  endfunction

  // Moves the cursor to the start of the next row; on the last row the grid
  // scrolls up instead and the bottom row is blanked in the current colours.
  function automatic logic advance_line();
    cur_col = 0;
    if (cur_row + 1 >= ROWS) begin
      cur_row = ROWS - 1;
      for (int unsigned i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
      blank_from(CELLS - COLUMNS);
      return 1'b1;
    end
    cur_row++;
    return 1'b0;
  endfunction

  function automatic out_item_t console_step(input in_item_t cmd);
    out_item_t res;
    res = '0;
    case (cmd.mode)
      MODE_PUT: begin
        if (cmd.char_code == CHAR_NEWLINE) begin
          res.scrolled = advance_line();
        end else begin
          // A character on a full line wraps first and is never lost.
          if (cur_col >= COLUMNS) res.scrolled = advance_line();
          screen[cur_row * COLUMNS + cur_col] = coloured(cmd.char_code);
          cur_col++;
        end
        res.cursor_update = cmd.last_char && cursor_on && (cur_col < COLUMNS);
      end
      MODE_CLEAR: begin
        blank_from(0);
        cur_row = 0;
        cur_col = 0;
      end
      MODE_READ: begin
        if (cmd.cell_row < ROWS && cmd.cell_col < COLUMNS)
          res.read_cell = screen[cmd.cell_row * COLUMNS + cmd.cell_col];
      end
      default: ;
    endcase
    res.cursor_row    = ROW_OUT_W'(cur_row);
    res.cursor_col    = COL_OUT_W'(cur_col);
    res.cursor_offset = OFS_OUT_W'(cur_row * COLUMNS + cur_col);
    return res;
  endfunction

  // ------------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------------
  function automatic in_item_t make_cmd(input logic [1:0] mode, input logic [7:0] ch,
                                        input logic last, input logic [4:0] row,
                                        input logic [6:0] col);
    in_item_t c;
    c.mode      = mode;
    c.char_code = ch;
    c.last_char = last;
    c.cell_row  = row;
    c.cell_col  = col;
    return c;
  endfunction

  function automatic logic [7:0] rand_glyph();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CHAR_NEWLINE);
    return c;
  endfunction

  // Called just after a falling edge; returns just after the falling edge
  // that follows the transfer, with in_valid still high.
  task automatic send_cmd(input in_item_t cmd);
    out_item_t want;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = cmd;
    do @(posedge clk); while (!in_ready);
    want = console_step(cmd);
    expected_results.push_back(want);
    n_sent++;
    if (want.scrolled) n_scrolls++;
    if (cmd.mode == MODE_CLEAR) n_clears++;
    if (cmd.mode == MODE_READ) n_reads++;
    @(negedge clk);
  endtask

  task automatic put_char(input logic [7:0] ch, input logic last);
    send_cmd(make_cmd(MODE_PUT, ch, last, 5'($urandom_range(0, 31)),
                      7'($urandom_range(0, 127))));
  endtask

  task automatic read_at(input logic [4:0] row, input logic [6:0] col);
    send_cmd(make_cmd(MODE_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      row, col));
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_BG:        bg_colour = val;
      REG_FG:        fg_colour = val;
      REG_CURSOR_EN: cursor_on = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_colours(input logic [3:0] bg, input logic [3:0] fg, input logic cur);
    wait_idle();
    write_reg(REG_BG, bg);
    write_reg(REG_FG, fg);
    write_reg(REG_CURSOR_EN, {3'($urandom_range(0, 7)), cur});
  endtask

  // ------------------------------------------------------------------------
  // Result checking
  // ------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing outstanding", out_data.cursor_offset, 0);
      end else begin
        want = expected_results.pop_front();
        n_checked++;
        if (out_data.cursor_row !== want.cursor_row)
          report_mismatch("cursor_row", out_data.cursor_row, want.cursor_row);
        if (out_data.cursor_col !== want.cursor_col)
          report_mismatch("cursor_col", out_data.cursor_col, want.cursor_col);
        if (out_data.cursor_offset !== want.cursor_offset)
          report_mismatch("cursor_offset", out_data.cursor_offset, want.cursor_offset);
        if (out_data.cursor_update !== want.cursor_update)
          report_mismatch("cursor_update", out_data.cursor_update, want.cursor_update);
        if (out_data.read_cell !== want.read_cell)
          report_mismatch("read_cell", out_data.read_cell, want.read_cell);
        if (out_data.scrolled !== want.scrolled)
          report_mismatch("scrolled", out_data.scrolled, want.scrolled);
      end
    end
  end

  // The receiver stalls at random, or for a whole hold-off when one is asked.
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      out_ready = ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------
  task automatic test_directed();
    put_char(8'h48, 1'b0);
    put_char(8'h00, 1'b0);
    put_char(8'hff, 1'b1);
    put_char(CHAR_NEWLINE, 1'b1);
    put_char(8'h78, 1'b1);
    read_at(5'd0, 7'd0);
    read_at(5'd0, 7'd1);
    read_at(5'd0, 7'd2);
    read_at(5'd1, 7'd0);
    read_at(5'(ROWS - 1), 7'(COLUMNS - 1));
    read_at(5'(ROWS), 7'd0);
    read_at(5'd31, 7'd127);
    read_at(5'd0, 7'(COLUMNS));
    send_cmd(make_cmd(MODE_UNUSED, 8'hff, 1'b1, 5'd31, 7'd127));
    // Cursor off via a data word whose low bit is clear; index 3 is ignored.
    wait_idle();
    write_reg(REG_BG, 4'hf);
    write_reg(REG_FG, 4'h0);
    write_reg(REG_CURSOR_EN, 4'he);
    write_reg(REG_NONE, 4'hf);
    put_char(8'h61, 1'b1);
    read_at(5'd1, 7'd1);
    wait_idle();
    write_reg(REG_CURSOR_EN, 4'h1);
    send_cmd(make_cmd(MODE_CLEAR, 8'h00, 1'b0, 5'd0, 7'd0));
    read_at(5'd0, 7'd0);
    read_at(5'd1, 7'd0);
    put_char(CHAR_NEWLINE, 1'b1);
  endtask

  task automatic test_wrap_and_scroll();
    set_colours(4'h1, 4'he, 1'b1);
    // Fill a line exactly, then let the next character wrap.
    for (int unsigned i = 0; i < COLUMNS; i++) put_char(rand_glyph(), i == COLUMNS - 1);
    put_char(rand_glyph(), 1'b1);
    read_at(5'(cur_row), 7'd0);
    read_at(5'(cur_row - 1), 7'(COLUMNS - 1));
    while (cur_row < ROWS - 1) put_char(CHAR_NEWLINE, 1'($urandom_range(0, 1)));
    put_char(rand_glyph(), 1'b0);
    put_char(rand_glyph(), 1'b1);
    put_char(CHAR_NEWLINE, 1'b1);
    put_char(CHAR_NEWLINE, 1'b0);
    read_at(5'(ROWS - 3), 7'd0);
    read_at(5'(ROWS - 3), 7'd1);
    // A full last row followed by one more character wraps and scrolls.
    for (int unsigned i = 0; i < COLUMNS; i++) put_char(rand_glyph(), 1'b0);
    put_char(rand_glyph(), 1'b1);
    read_at(5'(ROWS - 2), 7'd0);
    read_at(5'(ROWS - 2), 7'(COLUMNS - 1));
    read_at(5'(ROWS - 1), 7'd0);
    read_at(5'(ROWS - 1), 7'd1);
  endtask

  task automatic test_backpressure();
    wait_idle();
    @(posedge clk);
    hold_request = HOLD_CYCLES;
    @(negedge clk);
    for (int unsigned i = 0; i < 12; i++) put_char(rand_glyph(), i == 11);
    read_at(5'(cur_row), 7'd3);
    put_char(CHAR_NEWLINE, 1'b1);
    read_at(5'(ROWS - 1), 7'd0);
  endtask

  task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                     input int unsigned count);
    int unsigned first;
    int unsigned kind;
    int unsigned len;
    logic [4:0]  row;
    logic [6:0]  col;
    first        = n_sent;
    in_idle_pct  = send_pct;
    out_idle_pct = recv_pct;
    while (n_sent - first < count) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        // A string of text, with the odd newline, closed by last_char.
        len = $urandom_range(1, 24);
        for (int unsigned k = 0; k < len; k++)
          put_char(($urandom_range(0, 9) == 0) ? CHAR_NEWLINE : rand_glyph(), k == len - 1);
      end else if (kind < 88) begin
        len = $urandom_range(1, 4);
        for (int unsigned k = 0; k < len; k++) begin
          case ($urandom_range(0, 7)) inside
            0:       row = 5'($urandom_range(0, 31));
            [1:3]:   row = 5'(cur_row);
            default: row = 5'($urandom_range(0, ROWS - 1));
          endcase
          col = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                            : 7'($urandom_range(0, COLUMNS - 1));
          read_at(row, col);
        end
      end else if (kind < 94) begin
        put_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else if (kind < 97) begin
        send_cmd(make_cmd(MODE_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          5'($urandom_range(0, 31)), 7'($urandom_range(0, 127))));
      end else begin
        send_cmd(make_cmd(MODE_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          5'($urandom_range(0, 31)), 7'($urandom_range(0, 127))));
      end
    end
  endtask

  // ------------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------------
  initial begin
    bg_colour = RESET_BG;
    fg_colour = RESET_FG;
    cursor_on = RESET_CURSOR_EN;
    cur_row   = 0;
    cur_col   = 0;
    blank_from(0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_wrap_and_scroll();
    test_backpressure();
    set_colours(4'h0, 4'h0, 1'b1);
    test_random_traffic(19, 55, 90);
    set_colours(4'hf, 4'hf, 1'b0);
    test_random_traffic(55, 19, 90);
    set_colours(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), 1'b1);
    test_random_traffic(0, 0, 90);

    wait_idle();
    repeat (4000) @(negedge clk);

    $display("Covered %0d commands: %0d reads, %0d clears and %0d scrolls; %0d results checked.",
             n_sent, n_reads, n_clears, n_scrolls, n_checked);
    $display("Ran three idling profiles and a %0d-cycle receiver hold-off; %0d mismatches.",
             HOLD_CYCLES, err_count);
    if (err_count == 0) begin
      $display("tb_text_console_cell_writer_top: done, clean");
    end else begin
      $display("tb_text_console_cell_writer_top: done, errors");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timed out with %0d results outstanding.", expected_results.size());
    $display("tb_text_console_cell_writer_top: done, errors");
    $finish;
  end

endmodule

### sim.f
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/tcw_ctrl.sv
rtl/tcw_datapath.sv
rtl/text_console_cell_writer_top.sv
verif/tb_text_console_cell_writer_top.sv
